// ===== rtl/core/thsh_pkg.sv =====
package thsh_pkg;

  localparam int SAMPLE_COUNT_DEF = 25;
  localparam int ADC_BITS_DEF     = 12;

  localparam int SMP_W   = 12;
  localparam int TEMP_W  = 16;
  localparam int STAT_W  = 2;
  localparam int RES_W   = 24;
  localparam int COEF_W  = 40;
  localparam int CFG_W   = 40;
  localparam int CIDX_W  = 2;

  localparam int LOG_W     = 47;
  localparam int K_W       = 6;
  localparam int FRAC_W    = 32;
  localparam int L2_W      = K_W + FRAC_W;
  localparam int MOP_W     = 48;
  localparam int MHALF_W   = 24;
  localparam int MACC_W    = 96;
  localparam int S_W       = 64;
  localparam int DIV_W     = 57;
  localparam int CNT_W     = 6;
  localparam int LOG_STEPS = 32;
  localparam int MUL_PARTS = 4;

  localparam logic [31:0] LN2_Q32      = 32'hB17217F8;
  localparam logic [DIV_W-1:0] CENTI_ONE_Q48 = DIV_W'(100) << 48;
  localparam logic [DIV_W-1:0] ZERO_C_CENTI  = DIV_W'(27315);
  localparam logic [DIV_W-1:0] SAT_K         = DIV_W'(27315 + 32767);

  localparam logic [RES_W-1:0]  SERIES_RST = RES_W'(990000);
  localparam logic [COEF_W-1:0] COEF_A_RST = COEF_W'(64'd368881895217);
  localparam logic [COEF_W-1:0] COEF_B_RST = COEF_W'(64'd25610247487);
  localparam logic [COEF_W-1:0] COEF_C_RST = COEF_W'(64'd74487709);

  localparam logic [CIDX_W-1:0] CFG_SERIES = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_COEF_A = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COEF_B = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_COEF_C = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OPEN  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

  typedef enum logic [3:0] {
    S_ACC, S_CLASS, S_BRANCH, S_NORM, S_SQ, S_LSTORE, S_DIFF, S_MLOAD,
    S_MSTEP, S_MSTORE, S_SUM, S_SCHK, S_DLOAD, S_DSTEP, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_LN2, MUL_MM, MUL_M3, MUL_BL, MUL_CL3
  } mul_op_t;

  typedef struct packed {
    logic    acc;
    logic    last;
    logic    classify;
    logic    log_load;
    logic    log_sel;
    logic    norm_step;
    logic    sq_init;
    logic    sq_step;
    logic    log_store;
    logic    diff;
    logic    mul_load;
    logic    mul_step;
    logic [1:0] mul_pp;
    logic    mul_store;
    mul_op_t mul_op;
    logic    sum;
    logic    div_load;
    logic    div_step;
    logic    publish;
  } thsh_cmd_t;

  typedef struct packed {
    logic is_open;
    logic is_short;
    logic norm_done;
    logic nonpos;
    logic out_busy;
  } thsh_sts_t;

endpackage

// ===== rtl/core/thsh_ctrl.sv =====
module thsh_ctrl
  import thsh_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  thsh_sts_t sts,
  output thsh_cmd_t cmd,
  output logic      in_stall
);

  localparam int IDX_W = $clog2(SAMPLE_COUNT + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);
  localparam logic [CNT_W-1:0] LOG_LAST = CNT_W'(LOG_STEPS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_PARTS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             which_r, which_nxt;
  mul_op_t          mop_r, mop_nxt;
  logic             accept;
  logic             last;

  assign accept = in_valid && (state_r == S_ACC);
  assign last   = (idx_r == IDX_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      idx_r   <= '0;
      cnt_r   <= '0;
      which_r <= 1'b0;
      mop_r   <= MUL_LN2;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      which_r <= which_nxt;
      mop_r   <= mop_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    which_nxt = which_r;
    mop_nxt   = mop_r;
    case (state_r)
      S_ACC: begin
        if (accept) begin
          if (last) begin
            idx_nxt   = '0;
            state_nxt = S_CLASS;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_CLASS: state_nxt = S_BRANCH;
      S_BRANCH: begin
        if (sts.is_open || sts.is_short) begin
          state_nxt = S_FIN;
        end else begin
          which_nxt = 1'b0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LOG_LAST) state_nxt = S_LSTORE;
      end
      S_LSTORE: begin
        if (!which_r) begin
          which_nxt = 1'b1;
          state_nxt = S_NORM;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        mop_nxt   = MUL_LN2;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) state_nxt = S_MSTORE;
      end
      S_MSTORE: begin
        state_nxt = S_MLOAD;
        case (mop_r)
          MUL_LN2: mop_nxt = MUL_MM;
          MUL_MM:  mop_nxt = MUL_M3;
          MUL_M3:  mop_nxt = MUL_BL;
          MUL_BL:  mop_nxt = MUL_CL3;
          default: state_nxt = S_SUM;
        endcase
      end
      S_SUM: state_nxt = S_SCHK;
      S_SCHK: state_nxt = sts.nonpos ? S_FIN : S_DLOAD;
      S_DLOAD: begin
        cnt_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) state_nxt = S_ACC;
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = mop_r;
    cmd.mul_pp = cnt_r[1:0];
    cmd.log_sel = which_r;
    in_stall   = (state_r != S_ACC);
    case (state_r)
      S_ACC: begin
        cmd.acc  = accept;
        cmd.last = last;
      end
      S_CLASS: cmd.classify = 1'b1;
      S_BRANCH: begin
        cmd.log_load = !(sts.is_open || sts.is_short);
        cmd.log_sel  = 1'b0;
      end
      S_NORM: begin
        cmd.norm_step = !sts.norm_done;
        cmd.sq_init   = sts.norm_done;
      end
      S_SQ: cmd.sq_step = 1'b1;
      S_LSTORE: begin
        cmd.log_store = 1'b1;
        cmd.log_load  = !which_r;
      end
      S_DIFF:   cmd.diff      = 1'b1;
      S_MLOAD:  cmd.mul_load  = 1'b1;
      S_MSTEP:  cmd.mul_step  = 1'b1;
      S_MSTORE: cmd.mul_store = 1'b1;
      S_SUM:    cmd.sum       = 1'b1;
      S_DLOAD:  cmd.div_load  = 1'b1;
      S_DSTEP:  cmd.div_step  = 1'b1;
      S_FIN:    cmd.publish   = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/thsh_dp.sv =====
module thsh_dp
  import thsh_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int ADC_BITS     = ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  thsh_cmd_t                cmd,
  output thsh_sts_t                sts,
  input  logic [SMP_W-1:0]         in_adc_sample,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temp_centi_c,
  output logic [STAT_W-1:0]        out_status
);

  localparam int FS     = (1 << ADC_BITS) - 1;
  localparam int SMAX   = (ADC_BITS >= SMP_W) ? ((1 << SMP_W) - 1) : FS;
  localparam int FULL   = FS * SAMPLE_COUNT;
  localparam int FULL_W = $clog2(FULL + 1);
  localparam int SUM_W  = $clog2(SMAX * SAMPLE_COUNT + 1);
  localparam int CMP_W  = ((FULL_W > SUM_W) ? FULL_W : SUM_W) + 1;
  localparam logic [SMP_W-1:0]  SMASK  = SMP_W'(SMAX);
  localparam logic [CMP_W-1:0]  FULL_C = CMP_W'(FULL);
  localparam int NUM_W = RES_W + FULL_W;

  logic [RES_W-1:0]  series_r;
  logic [COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r;
  logic [SUM_W-1:0]  sum_r, grp_r, sum_nxt;
  logic              open_r, short_r, nonpos_r;
  logic [LOG_W-1:0]  num_r;
  logic [LOG_W-1:0]  x_r;
  logic [K_W-1:0]    k_r;
  logic [30:0]       y_r;
  logic [FRAC_W-1:0] frac_r;
  logic [L2_W-1:0]   l2n_r, l2d_r;
  logic              neg_r;
  logic [L2_W-1:0]   mag_r;
  logic [MOP_W-1:0]  ma_r, mb_r, lnm_r, mm_r, m3_r;
  logic [MACC_W-1:0] acc_r;
  logic [S_W-1:0]    bl_r, cl3_r, s_r;
  logic [DIV_W-1:0]  q_r, d_r, rem_r;
  logic              out_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [STAT_W-1:0] status_r;

  logic [CMP_W-1:0]     grp_ext;
  logic [FULL_W-1:0]    diff_w;
  logic [NUM_W-1:0]     num_w;
  logic [61:0]          sq_w;
  logic [31:0]          sq_s;
  logic [MHALF_W-1:0]   pa, pb;
  logic [2*MHALF_W-1:0] pp_w;
  logic [MACC_W-1:0]    pp_sh;
  logic [S_W-1:0]       mres, tot_w, s_w;
  logic [DIV_W:0]       trial;
  logic [DIV_W-1:0]     numer;

  assign sum_nxt = sum_r + SUM_W'(in_adc_sample & SMASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      series_r <= SERIES_RST;
      coef_a_r <= COEF_A_RST;
      coef_b_r <= COEF_B_RST;
      coef_c_r <= COEF_C_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SERIES: series_r <= cfg_wdata[RES_W-1:0];
        CFG_COEF_A: coef_a_r <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_B: coef_b_r <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_C: coef_c_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.acc) begin
      sum_r <= cmd.last ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && cmd.last) grp_r <= sum_nxt;
  end

  assign grp_ext = CMP_W'(grp_r);
  assign diff_w  = FULL_W'(FULL_C - grp_ext);
  assign num_w   = NUM_W'(series_r) * NUM_W'(diff_w);

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      open_r  <= (grp_r == '0);
      short_r <= (grp_ext >= FULL_C) || (series_r == '0);
      num_r   <= LOG_W'(num_w);
    end
  end

  assign sq_w = 62'(y_r) * 62'(y_r);
  assign sq_s = sq_w[61:30];

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      x_r <= (cmd.log_sel || cmd.log_store) ? LOG_W'(grp_r) : num_r;
      k_r <= K_W'(LOG_W - 1);
    end else if (cmd.norm_step && !x_r[LOG_W-1]) begin
      x_r <= {x_r[LOG_W-2:0], 1'b0};
      k_r <= k_r - 1'b1;
    end
    if (cmd.sq_init) begin
      y_r    <= x_r[LOG_W-1:LOG_W-31];
      frac_r <= '0;
    end else if (cmd.sq_step) begin
      y_r    <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
      frac_r <= {frac_r[FRAC_W-2:0], sq_s[31]};
    end
    if (cmd.log_store) begin
      if (cmd.log_sel) l2d_r <= {k_r, frac_r};
      else             l2n_r <= {k_r, frac_r};
    end
    if (cmd.diff) begin
      neg_r <= (l2n_r < l2d_r);
      mag_r <= (l2n_r < l2d_r) ? (l2d_r - l2n_r) : (l2n_r - l2d_r);
    end
  end

  assign pa    = cmd.mul_pp[0] ? ma_r[MOP_W-1:MHALF_W] : ma_r[MHALF_W-1:0];
  assign pb    = cmd.mul_pp[1] ? mb_r[MOP_W-1:MHALF_W] : mb_r[MHALF_W-1:0];
  assign pp_w  = pa * pb;
  assign mres  = acc_r[MACC_W-1:32];

  always_comb begin
    case (cmd.mul_pp)
      2'd0:    pp_sh = MACC_W'(pp_w);
      2'd3:    pp_sh = MACC_W'(pp_w) << (2 * MHALF_W);
      default: pp_sh = MACC_W'(pp_w) << MHALF_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      acc_r <= '0;
      case (cmd.mul_op)
        MUL_LN2: begin
          ma_r <= MOP_W'(mag_r);
          mb_r <= MOP_W'(LN2_Q32);
        end
        MUL_MM: begin
          ma_r <= lnm_r;
          mb_r <= lnm_r;
        end
        MUL_M3: begin
          ma_r <= mm_r;
          mb_r <= lnm_r;
        end
        MUL_BL: begin
          ma_r <= MOP_W'(coef_b_r);
          mb_r <= lnm_r;
        end
        default: begin
          ma_r <= MOP_W'(coef_c_r);
          mb_r <= m3_r;
        end
      endcase
    end else if (cmd.mul_step) begin
      acc_r <= acc_r + pp_sh;
    end
    if (cmd.mul_store) begin
      case (cmd.mul_op)
        MUL_LN2: lnm_r <= mres[MOP_W-1:0];
        MUL_MM:  mm_r  <= mres[MOP_W-1:0];
        MUL_M3:  m3_r  <= mres[MOP_W-1:0];
        MUL_BL:  bl_r  <= mres;
        default: cl3_r <= mres;
      endcase
    end
  end

  assign tot_w = bl_r + cl3_r;
  assign s_w   = neg_r ? (S_W'(coef_a_r) - tot_w) : (S_W'(coef_a_r) + tot_w);
  assign numer = CENTI_ONE_Q48 + s_r[DIV_W:1];
  assign trial = {rem_r, q_r[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      s_r      <= s_w;
      nonpos_r <= s_w[S_W-1] || (s_w == '0);
    end
    if (cmd.div_load) begin
      q_r   <= numer;
      d_r   <= s_r[DIV_W-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, d_r}) begin
        rem_r <= DIV_W'(trial - {1'b0, d_r});
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (open_r) begin
        temp_r   <= '0;
        status_r <= ST_OPEN;
      end else if (short_r) begin
        temp_r   <= '0;
        status_r <= ST_SHORT;
      end else if (nonpos_r || (q_r > SAT_K)) begin
        temp_r   <= TEMP_W'(32767);
        status_r <= ST_SAT;
      end else begin
        temp_r   <= TEMP_W'(q_r - ZERO_C_CENTI);
        status_r <= ST_OK;
      end
    end
  end

  assign sts.is_open   = open_r;
  assign sts.is_short  = short_r;
  assign sts.norm_done = x_r[LOG_W-1];
  assign sts.nonpos    = nonpos_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_temp_centi_c = temp_r;
  assign out_status       = status_r;

endmodule

// ===== rtl/core/thermistor_steinhart_hart_temp.sv =====
// NTC thermistor temperature converter.
// Raw ADC samples arrive on the in_ channel, one per transaction. Every
// SAMPLE_COUNT samples are summed, and the group yields one result on the
// out_ channel: a temperature in hundredths of a degree Celsius and a status
// code (ok, open, short, saturated).
// While a group is being collected a sample is taken in every cycle in which
// in_valid is high. After the last sample of a group in_stall stays high for
// the conversion: two bit-serial normalisations, two squaring loops for the
// logarithms, five 24-bit partial-product multiplications and a restoring
// divider for the reciprocal. Open and short groups skip the conversion.
// The result sits in an output register; a new group is collected while it
// waits. If the receiver still stalls when the next result is ready, the
// converter holds it and keeps in_stall high until the slot frees.
// The cfg_ port writes the divider resistor and the three coefficients;
// writes are meant for idle periods. Synchronous reset restores the default
// coefficients and clears the running sum and sample count.
module thermistor_steinhart_hart_temp
  import thsh_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int ADC_BITS     = ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SMP_W-1:0]         in_adc_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] out_temp_centi_c,
  output logic [STAT_W-1:0]        out_status,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  thsh_cmd_t cmd;
  thsh_sts_t sts;

  thsh_ctrl #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .sts     (sts),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  thsh_dp #(
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .ADC_BITS    (ADC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_adc_sample   (in_adc_sample),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_temp_centi_c(out_temp_centi_c),
    .out_status      (out_status)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid && out_stall))
    else $error("result published over a pending transaction");

  a_group_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && cmd.last) |=> in_stall)
    else $error("input not stalled after the last sample of a group");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.norm_step, cmd.sq_step, cmd.mul_step, cmd.div_step}))
    else $error("more than one datapath step in a cycle");

endmodule
